[sv/ptua_pkg.sv]
// ----------------------------------------------------------------------------
// ptua_pkg
// Shared widths, op codes and payload types for the per-tag usage accounting
// block.
// ----------------------------------------------------------------------------
package ptua_pkg;

	localparam int NUM_TAGS = 16;
	localparam int BYTE_W   = 48;
	localparam int COUNT_W  = 32;
	localparam int TAG_W    = 4;
	localparam int OP_W     = 3;
	localparam int IDX_W    = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

	localparam logic [OP_W-1:0] OP_ALLOC       = 3'd0;
	localparam logic [OP_W-1:0] OP_FREE        = 3'd1;
	localparam logic [OP_W-1:0] OP_BUDGET      = 3'd2;
	localparam logic [OP_W-1:0] OP_READ        = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET_STATS = 3'd4;

	typedef logic [BYTE_W-1:0]  bytes_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [TAG_W-1:0] tag;
		bytes_t           amount;
	} cmd_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag_out;
		bytes_t           in_use_bytes;
		bytes_t           peak_bytes;
		count_t           alloc_count;
		bytes_t           budget_bytes;
		logic             budget_set;
		logic             over_budget;
	} rsp_t;

	// one table entry as stored in the memory
	typedef struct packed {
		bytes_t live;
		bytes_t peak;
		count_t count;
		bytes_t budget;
		logic   bset;
	} entry_t;

	typedef struct packed {
		logic   en;
		idx_t   addr;
		entry_t data;
	} mem_wr_t;

endpackage

[sv/ptua_cmd_if.sv]
// ----------------------------------------------------------------------------
// ptua_cmd_if
// Command channel: valid/ready handshake carrying op, tag and amount.
// ----------------------------------------------------------------------------
interface ptua_cmd_if import ptua_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/ptua_rsp_if.sv]
// ----------------------------------------------------------------------------
// ptua_rsp_if
// Response channel: valid/ready handshake carrying one reported entry.
// ----------------------------------------------------------------------------
interface ptua_rsp_if import ptua_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[sv/per_tag_usage_accounting.sv]
// ----------------------------------------------------------------------------
// per_tag_usage_accounting
// Per-tag table of live bytes, peak bytes, allocation count and budget.
// ----------------------------------------------------------------------------
// One transaction on cmd carries op, tag and amount; each produces exactly one
// transaction on rsp with the addressed entry after the op. The edge that
// accepts an item reads the entry from the entry store; once the result
// register is free or being drained, the updated entry is written back and
// the result register loaded, and the result is offered on rsp from there.
// cmd.ready stays low while an item sits between read and write-back, so a
// new item is not taken before the last one is written back; a result
// waiting on rsp lets one more item be read in, after which the block holds
// until rsp is drained. Reset statistics passes through stage 1 like any other
// op: per-tag flags mark every entry's peak and count as stale and the next
// access to that entry folds them in. Likewise per-tag valid flags make
// never-written entries read as zero, so there is no clearing pass after reset.
// The tracking switch resets to 1 and is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module per_tag_usage_accounting import ptua_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_wr_en,
	input  logic  cfg_wr_data,
	ptua_cmd_if.sink   cmd,
	ptua_rsp_if.source rsp
);

	// configuration
	logic tracking_q;

	// stage 1: item whose entry has been read
	logic            v_s1;
	logic [OP_W-1:0] op_s1;
	logic [TAG_W-1:0] tag_s1;
	bytes_t          amount_s1;

	// per-tag flags in flops
	logic [NUM_TAGS-1:0] valid_q;
	logic [NUM_TAGS-1:0] stale_q;

	// result register
	logic rsp_v_q;
	rsp_t rsp_q;

	logic    acc;
	logic    move;
	logic    in_range_s1;
	idx_t    idx_s1;
	entry_t  rd_entry;
	entry_t  nxt;
	logic    over;
	mem_wr_t wr;
	rsp_t    res;

	assign cmd.ready = !v_s1;
	assign acc       = cmd.valid && cmd.ready;
	// stage 1 retires when the result register is free or being drained
	assign move      = v_s1 && (!rsp_v_q || rsp.ready);

	assign idx_s1      = IDX_W'(tag_s1);
	assign in_range_s1 = 32'(tag_s1) < NUM_TAGS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b1;
		end else if (cfg_wr_en) begin
			tracking_q <= cfg_wr_data;
		end
	end

	ptua_mem u_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (IDX_W'(cmd.data.tag)),
		.rd_data (rd_entry),
		.wr      (wr)
	);

	ptua_upd u_upd (
		.op       (op_s1),
		.amount   (amount_s1),
		.tracking (tracking_q),
		.raw      (rd_entry),
		.valid    (valid_q[idx_s1]),
		.stale    (stale_q[idx_s1]),
		.nxt      (nxt),
		.over     (over)
	);

	// reset statistics touches only the flags; every other op writes back
	assign wr = {move && in_range_s1 && (op_s1 != OP_RESET_STATS), idx_s1, nxt};

	always_comb begin
		res         = '0;
		res.tag_out = tag_s1;
		if (in_range_s1) begin
			res.in_use_bytes = nxt.live;
			res.peak_bytes   = nxt.peak;
			res.alloc_count  = nxt.count;
			res.budget_bytes = nxt.bset ? nxt.budget : '0;
			res.budget_set   = nxt.bset;
			res.over_budget  = over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (move) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1     <= cmd.data.op;
			tag_s1    <= cmd.data.tag;
			amount_s1 <= cmd.data.amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			stale_q <= '0;
		end else if (move) begin
			if (op_s1 == OP_RESET_STATS) begin
				stale_q <= '1;
			end else if (in_range_s1) begin
				valid_q[idx_s1] <= 1'b1;
				stale_q[idx_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (move) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	// one read-modify-write in flight: no two transactions on consecutive edges
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !acc)
		else $error("command accepted on consecutive cycles");

	// peak can never trail live bytes
	a_peak_ge_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.data.peak_bytes >= rsp.data.in_use_bytes))
		else $error("reported peak below live bytes");

	// over budget only with a budget in place
	a_over_needs_budget: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.over_budget |-> rsp.data.budget_set)
		else $error("over budget without a budget");

	// a statistics reset reports a zero count
	a_reset_stats_count: assert property (@(posedge clk) disable iff (!arst_n)
		move && (op_s1 == OP_RESET_STATS) |=> (rsp.data.alloc_count == '0))
		else $error("count not cleared by statistics reset");

endmodule

[sv/ptua_mem.sv]
// ----------------------------------------------------------------------------
// ptua_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptua_mem import ptua_pkg::*; (
	input  logic    clk,
	input  logic    rd_en,
	input  idx_t    rd_addr,
	output entry_t  rd_data,
	input  mem_wr_t wr
);

	entry_t mem_q [NUM_TAGS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/ptua_upd.sv]
// ----------------------------------------------------------------------------
// ptua_upd
// Entry update: applies one op to the entry read back from the store.
// ----------------------------------------------------------------------------
module ptua_upd import ptua_pkg::*; (
	input  logic [OP_W-1:0] op,
	input  bytes_t          amount,
	input  logic            tracking,
	input  entry_t          raw,
	input  logic            valid,
	input  logic            stale,
	output entry_t          nxt,
	output logic            over
);

	entry_t          cur;
	logic [BYTE_W:0] sum;
	logic            active;

	// never-written entry reads as zero; stale stats read as peak = live, count = 0
	always_comb begin
		cur = raw;
		if (!valid) begin
			cur = '0;
		end else if (stale) begin
			cur.peak  = raw.live;
			cur.count = '0;
		end
	end

	assign active = tracking && (amount != '0);
	assign sum    = {1'b0, cur.live} + {1'b0, amount};

	always_comb begin
		nxt = cur;
		unique case (op)
			OP_ALLOC: begin
				if (active) begin
					nxt.live = sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
					if (nxt.live > cur.peak) begin
						nxt.peak = nxt.live;
					end
					if (cur.count != '1) begin
						nxt.count = cur.count + 1'b1;
					end
				end
			end
			OP_FREE: begin
				if (active) begin
					nxt.live = (amount >= cur.live) ? '0 : cur.live - amount;
				end
			end
			OP_BUDGET: begin
				nxt.budget = amount;
				nxt.bset   = 1'b1;
			end
			OP_RESET_STATS: begin
				// reported entry already shows the statistics reset
				nxt.peak  = cur.live;
				nxt.count = '0;
			end
			default: begin
				// read and unused codes leave the entry as is
			end
		endcase
	end

	assign over = nxt.bset && (nxt.live > nxt.budget);

endmodule
